// File: rtl/core/cs_pkg.sv
// Shared types, constants and helper functions for the Cartesian/spherical converter.
// Depends on nothing; every file but the two channel interfaces imports it.
package cs_pkg;

  // Internal datapath width: Q30 angles and coordinates scaled by four, with CORDIC headroom
  localparam int W         = 38;
  localparam int MAX_STEPS = 32;

  // Default number of CORDIC micro-rotations per pass
  localparam int unsigned STEPS_DEF = 24;

  typedef logic signed [W-1:0] word_t;

  localparam word_t GAIN_Q30    = 38'sd652032874;
  localparam word_t PI_Q30      = 38'sd3373259426;
  localparam word_t HALF_PI_Q30 = 38'sd1686629713;
  localparam word_t TWO_PI_Q30  = 38'sd6746518852;
  localparam word_t COORD_LIM   = 38'sd1073741824;

  localparam logic OP_TO_SPH  = 1'b0;
  localparam logic OP_TO_CART = 1'b1;

  // One item in flight through the pipeline
  typedef struct packed {
    logic  vld;
    logic  op;
    logic  zf;    // zero vector: force the pass result to zero
    logic  flip;  // angle was folded by pi: negate the rotated vector
    word_t x;
    word_t y;
    word_t a;
    word_t aux;
  } item_t;

  typedef struct packed {
    word_t ang;
    logic  flip;
  } ang_t;

  // Truncated arctangent table, 2^-30 rad per LSB
  function automatic word_t atan_q30(input int unsigned i);
    logic [31:0] t;
    unique case (i)
      0: t = 32'h3243F6A8;   1: t = 32'h1DAC6705;   2: t = 32'h0FADBAFC;
      3: t = 32'h07F56EA6;   4: t = 32'h03FEAB76;   5: t = 32'h01FFD55B;
      6: t = 32'h00FFFAAA;   7: t = 32'h007FFF55;   8: t = 32'h003FFFEA;
      9: t = 32'h001FFFFD;  10: t = 32'h000FFFFF;  11: t = 32'h0007FFFF;
      12: t = 32'h0003FFFF; 13: t = 32'h0001FFFF;  14: t = 32'h0000FFFF;
      15: t = 32'h00007FFF; 16: t = 32'h00003FFF;  17: t = 32'h00001FFF;
      18: t = 32'h00000FFF; 19: t = 32'h000007FF;  20: t = 32'h000003FF;
      21: t = 32'h000001FF; 22: t = 32'h000000FF;  23: t = 32'h0000007F;
      24: t = 32'h0000003F; 25: t = 32'h0000001F;  26: t = 32'h0000000F;
      27: t = 32'h00000008; 28: t = 32'h00000004;  29: t = 32'h00000002;
      30: t = 32'h00000001;
      default: t = 32'h00000000;
    endcase
    return word_t'({{(W-32){1'b0}}, t});
  endfunction

  // Clamp a coordinate to +-2^30 and scale by the two guard bits
  function automatic word_t clamp_scale(input logic signed [31:0] v);
    word_t e;
    e = word_t'(v);
    if (e > COORD_LIM) e = COORD_LIM;
    else if (e < -COORD_LIM) e = -COORD_LIM;
    return e <<< 2;
  endfunction

  // Wrap a Q4.28 angle into [-pi, pi], then fold into [-pi/2, pi/2]
  function automatic ang_t wrap_fold(input logic signed [31:0] q28);
    ang_t r;
    r.ang  = word_t'(q28) <<< 2;
    r.flip = 1'b0;
    if (r.ang > PI_Q30) r.ang = r.ang - TWO_PI_Q30;
    else if (r.ang < -PI_Q30) r.ang = r.ang + TWO_PI_Q30;
    if (r.ang > HALF_PI_Q30) begin
      r.ang  = r.ang - PI_Q30;
      r.flip = 1'b1;
    end else if (r.ang < -HALF_PI_Q30) begin
      r.ang  = r.ang + PI_Q30;
      r.flip = 1'b1;
    end
    return r;
  endfunction

  // Round half up by two bits, then saturate to 32 bits signed
  function automatic logic signed [31:0] round_sat(input word_t v);
    word_t s;
    s = (v + word_t'(2)) >>> 2;
    if (s > word_t'(32'sh7FFFFFFF)) return 32'sh7FFFFFFF;
    if (s < word_t'(-38'sd2147483648)) return -32'sd2147483648;
    return s[31:0];
  endfunction

endpackage

// File: rtl/core/cs_in_if.sv
// Input channel of the converter: valid/ready handshake with op and three coordinates.
// Depends on nothing.
interface cs_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] in_a;
  logic signed [31:0] in_b;
  logic signed [31:0] in_c;

  modport source (output valid, op, in_a, in_b, in_c, input ready);
  modport sink   (input valid, op, in_a, in_b, in_c, output ready);
endinterface

// File: rtl/core/cs_out_if.sv
// Output channel of the converter: valid/ready handshake with three result fields.
// Depends on nothing.
interface cs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_a;
  logic signed [31:0] out_b;
  logic signed [31:0] out_c;

  modport source (output valid, out_a, out_b, out_c, input ready);
  modport sink   (input valid, out_a, out_b, out_c, output ready);
endinterface

// File: rtl/core/cartesian_spherical_converter.sv
// Top level of the Cartesian <-> range/azimuth/elevation converter: prep, two CORDIC
// passes with gain stages, output register. Depends on cs_pkg, cs_in_if, cs_out_if,
// cs_cordic and cs_scale.
//
//   channel  | dir | payload
//   ---------+-----+---------------------------------------
//   in_i     | in  | op, in_a, in_b, in_c (valid/ready)
//   out_o    | out | out_a, out_b, out_c (valid/ready)
//
// One item per cycle while the output is not stalled; the path runs through the two
// chained CORDIC pipelines plus prep registers, two gain multipliers and the output register.
// Reset clears all valid bits; no clearing pass.
// A stalled output freezes the whole pipeline; items hold in place, none lost.
module cartesian_spherical_converter
  import cs_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = STEPS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  cs_in_if.sink    in_i,
  cs_out_if.source out_o
);

  logic  en;
  item_t p1_d, p1_q, c1_out, g1_out, p2_d, p2_q, c2_out, g2_out;
  word_t h, az, c_v, s_v, xo, yo;
  ang_t  el_w, az_w;
  word_t xs, ys, zs;

  logic               out_vld_q;
  logic signed [31:0] oa_d, ob_d, oc_d, oa_q, ob_q, oc_q;

  // Advance everything when the output slot is free
  assign en       = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  // Prepare first pass
  always_comb begin
    xs   = clamp_scale(in_i.in_a);
    ys   = clamp_scale(in_i.in_b);
    zs   = clamp_scale(in_i.in_c);
    el_w = wrap_fold(in_i.in_c);
    p1_d = '0;
    p1_d.vld = in_i.valid;
    p1_d.op  = in_i.op;
    if (in_i.op == OP_TO_SPH) begin
      p1_d.zf  = (xs == 0) && (ys == 0);
      p1_d.x   = xs;
      p1_d.y   = ys;
      p1_d.aux = zs;
      if (xs < 0) begin
        if (ys >= 0) begin
          p1_d.x = ys;
          p1_d.y = -xs;
          p1_d.a = HALF_PI_Q30;
        end else begin
          p1_d.x = -ys;
          p1_d.y = xs;
          p1_d.a = -HALF_PI_Q30;
        end
      end
    end else begin
      p1_d.x    = xs;
      p1_d.a    = el_w.ang;
      p1_d.flip = el_w.flip;
      p1_d.aux  = word_t'(in_i.in_b);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q <= '0;
    end else if (en) begin
      p1_q <= p1_d;
    end
  end

  cs_cordic #(.STEPS(CORDIC_STEPS)) u_pass1 (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .item_i(p1_q), .item_o(c1_out)
  );

  cs_scale u_gain1 (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .item_i(c1_out), .item_o(g1_out)
  );

  // Prepare second pass
  always_comb begin
    h    = g1_out.zf ? '0 : g1_out.x;
    az   = g1_out.zf ? '0 : g1_out.a;
    c_v  = g1_out.flip ? -g1_out.x : g1_out.x;
    s_v  = g1_out.flip ? -g1_out.y : g1_out.y;
    az_w = wrap_fold(g1_out.aux[31:0]);
    p2_d = '0;
    p2_d.vld = g1_out.vld;
    p2_d.op  = g1_out.op;
    if (g1_out.op == OP_TO_SPH) begin
      p2_d.x   = h;
      p2_d.y   = g1_out.aux;
      p2_d.zf  = (h == 0) && (g1_out.aux == 0);
      p2_d.aux = az;
    end else begin
      p2_d.x    = c_v;
      p2_d.a    = az_w.ang;
      p2_d.flip = az_w.flip;
      p2_d.aux  = s_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_q <= '0;
    end else if (en) begin
      p2_q <= p2_d;
    end
  end

  cs_cordic #(.STEPS(CORDIC_STEPS)) u_pass2 (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .item_i(p2_q), .item_o(c2_out)
  );

  cs_scale u_gain2 (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .item_i(c2_out), .item_o(g2_out)
  );

  // Round, saturate and select results
  always_comb begin
    xo = g2_out.flip ? -g2_out.x : g2_out.x;
    yo = g2_out.flip ? -g2_out.y : g2_out.y;
    if (g2_out.op == OP_TO_SPH) begin
      oa_d = round_sat(g2_out.zf ? '0 : g2_out.x);
      ob_d = round_sat(g2_out.aux);
      oc_d = round_sat(g2_out.zf ? '0 : -g2_out.a);
    end else begin
      oa_d = round_sat(xo);
      ob_d = round_sat(yo);
      oc_d = round_sat(-g2_out.aux);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= g2_out.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      oa_q <= oa_d;
      ob_q <= ob_d;
      oc_q <= oc_d;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.out_a = oa_q;
  assign out_o.out_b = ob_q;
  assign out_o.out_c = oc_q;

  // A frozen pipeline keeps its valid bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(p1_q.vld) && $stable(p2_q.vld)))
    else $error("valid bits moved during stall");

  // A new result only appears after an advancing cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(en))
    else $error("result appeared without pipeline advance");

  // Second pass input register takes the first pass gain stage output on each advance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en |=> (p2_q.vld == $past(g1_out.vld)))
    else $error("valid lost between passes");

endmodule

// File: rtl/core/cs_cordic_stage.sv
// One registered CORDIC micro-rotation; vectoring for op 0, rotation for op 1.
// Depends on cs_pkg.
module cs_cordic_stage
  import cs_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  item_t item_i,
  output item_t item_o
);

  localparam word_t ATAN = atan_q30(IDX);

  item_t item_d, item_q;
  word_t dx, dy;
  logic  pos;

  // Pick direction and rotate by one step
  always_comb begin
    dx     = item_i.y >>> IDX;
    dy     = item_i.x >>> IDX;
    pos    = (item_i.op == OP_TO_SPH) ? (item_i.y >= 0) : (item_i.a < 0);
    item_d = item_i;
    if (pos) begin
      item_d.x = item_i.x + dx;
      item_d.y = item_i.y - dy;
      item_d.a = item_i.a + ATAN;
    end else begin
      item_d.x = item_i.x - dx;
      item_d.y = item_i.y + dy;
      item_d.a = item_i.a - ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else if (en_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

// File: rtl/core/cs_cordic.sv
// Chain of STEPS registered micro-rotation stages.
// Depends on cs_pkg and cs_cordic_stage.
module cs_cordic
  import cs_pkg::*;
#(
  parameter int unsigned STEPS = STEPS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  item_t item_i,
  output item_t item_o
);

  item_t chain [STEPS+1];

  assign chain[0] = item_i;

  // Build one stage per micro-rotation
  for (genvar g = 0; g < STEPS; g++) begin : g_stage
    cs_cordic_stage #(.IDX(g)) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .item_i (chain[g]),
      .item_o (chain[g+1])
    );
  end

  assign item_o = chain[STEPS];

endmodule

// File: rtl/core/cs_scale.sv
// Gain correction stage: multiplies x and y by the inverse CORDIC gain limit, rounds half up.
// Depends on cs_pkg.
module cs_scale
  import cs_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  item_t item_i,
  output item_t item_o
);

  localparam int PW = 2 * W;

  logic signed [PW-1:0] px, py;
  item_t item_d, item_q;

  // Multiply and round by 30 bits
  always_comb begin
    px       = PW'(item_i.x) * PW'(GAIN_Q30);
    py       = PW'(item_i.y) * PW'(GAIN_Q30);
    item_d   = item_i;
    item_d.x = W'((px + (PW'(1) <<< 29)) >>> 30);
    item_d.y = W'((py + (PW'(1) <<< 29)) >>> 30);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else if (en_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

// File: tb/cs_conv_checker.sv
// Checker for the Cartesian/spherical converter: watches both channels, predicts each
// point with its own fixed-point CORDIC and compares field by field. Depends on cs_pkg.
module cs_conv_checker
  import cs_pkg::*;
#(
  parameter int unsigned STEPS = STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               in_op_i,
  input  logic signed [31:0] in_a_i,
  input  logic signed [31:0] in_b_i,
  input  logic signed [31:0] in_c_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] out_a_i,
  input  logic signed [31:0] out_b_i,
  input  logic signed [31:0] out_c_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 checked_o
);

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
  } point_t;

  localparam longint LIM      = 64'sd1073741824;
  localparam longint GAIN     = 64'sd652032874;
  localparam longint PI30     = 64'sd3373259426;
  localparam longint HALFPI30 = 64'sd1686629713;

  localparam longint ARCTAN [32] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
    64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
    64'h00000001, 64'h00000000
  };

  point_t expected_pts[$];
  int     errors;
  int     checked;

  assign errors_o  = errors;
  assign pending_o = expected_pts.size();
  assign checked_o = checked;

  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint limit4(logic signed [31:0] v);
    longint e;
    e = longint'(v);
    if (e > LIM) e = LIM;
    else if (e < -LIM) e = -LIM;
    return e * 4;
  endfunction

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint unscale(longint v);
    return rnd_shift(v * GAIN, 30);
  endfunction

  // Drive y to zero, accumulate the angle
  function automatic void vectorize(inout longint x, inout longint y, inout longint ang);
    longint dx, dy;
    for (int i = 0; i < STEPS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; ang += ARCTAN[i];
      end else begin
        x -= dx; y += dy; ang -= ARCTAN[i];
      end
    end
  endfunction

  // Rotate (r, 0) by a Q4.28 angle over the full circle, gain removed
  function automatic void spin(longint r, logic signed [31:0] q28,
                               output longint co, output longint si);
    longint ang, x, y, dx, dy;
    bit     fold;
    ang  = longint'(q28) * 4;
    fold = 0;
    if (ang > PI30) ang -= 2 * PI30;
    else if (ang < -PI30) ang += 2 * PI30;
    if (ang > HALFPI30) begin
      ang -= PI30; fold = 1;
    end else if (ang < -HALFPI30) begin
      ang += PI30; fold = 1;
    end
    x = r;
    y = 0;
    for (int i = 0; i < STEPS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (ang >= 0) begin
        x -= dx; y += dy; ang -= ARCTAN[i];
      end else begin
        x += dx; y -= dy; ang += ARCTAN[i];
      end
    end
    co = unscale(x);
    si = unscale(y);
    if (fold) begin
      co = -co; si = -si;
    end
  endfunction

  function automatic point_t convert_point(logic op, logic signed [31:0] a,
                                           logic signed [31:0] b, logic signed [31:0] c);
    point_t p;
    longint x, y, z, az, el, h, rng, t, rc, rs, xo, yo;
    if (op == OP_TO_SPH) begin
      x = limit4(a); y = limit4(b); z = limit4(c);
      az = 0; el = 0;
      if (x == 0 && y == 0) begin
        h = 0;
      end else begin
        // Pre-rotate the left half plane by a quarter turn
        if (x < 0) begin
          t = x;
          if (y >= 0) begin
            x = y; y = -t; az = HALFPI30;
          end else begin
            x = -y; y = t; az = -HALFPI30;
          end
        end
        vectorize(x, y, az);
        h = unscale(x);
      end
      if (h == 0 && z == 0) begin
        rng = 0;
      end else begin
        vectorize(h, z, el);
        rng = unscale(h);
      end
      p.a = sat32(rnd_shift(rng, 2));
      p.b = sat32(rnd_shift(az, 2));
      p.c = sat32(rnd_shift(-el, 2));
    end else begin
      spin(limit4(a), c, rc, rs);
      spin(rc, b, xo, yo);
      p.a = sat32(rnd_shift(xo, 2));
      p.b = sat32(rnd_shift(yo, 2));
      p.c = sat32(rnd_shift(-rs, 2));
    end
    return p;
  endfunction

  task automatic report_mismatch(string what, logic signed [31:0] got,
                                 logic signed [31:0] want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Predict on input accept, compare on output accept
  always @(posedge clk_i or negedge rst_ni) begin
    point_t want;
    if (!rst_ni) begin
      errors  = 0;
      checked = 0;
      expected_pts.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_pts.size() == 0) begin
          $display("MISMATCH: result with nothing expected");
          errors++;
        end else begin
          want = expected_pts.pop_front();
          if (out_a_i !== want.a) report_mismatch("out_a", out_a_i, want.a);
          if (out_b_i !== want.b) report_mismatch("out_b", out_b_i, want.b);
          if (out_c_i !== want.c) report_mismatch("out_c", out_c_i, want.c);
          checked++;
        end
      end
      if (in_valid_i && in_ready_i)
        expected_pts.push_back(convert_point(in_op_i, in_a_i, in_b_i, in_c_i));
    end
  end

endmodule

// File: tb/tb.sv
// Top of the converter testbench: clock, reset, stimulus with bursts and stalls, verdict.
// Depends on cs_pkg, cs_in_if, cs_out_if, cartesian_spherical_converter, cs_conv_checker.
module tb
  import cs_pkg::*;
();

  localparam int STEPS   = STEPS_DEF;
  localparam int LATENCY = 2 * STEPS + 5;
  localparam int LIMIT   = 400000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   cycles = 0;
  int   errors, pending, checked;
  int   n_sph  = 0;
  int   n_cart = 0;
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;
  int   hold_cnt  = 0;

  cs_in_if  in_ch ();
  cs_out_if out_ch ();

  cartesian_spherical_converter #(.CORDIC_STEPS(STEPS)) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  cs_conv_checker #(.STEPS(STEPS)) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_i  (in_ch.ready),
    .in_op_i     (in_ch.op),
    .in_a_i      (in_ch.in_a),
    .in_b_i      (in_ch.in_b),
    .in_c_i      (in_ch.in_c),
    .out_valid_i (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_a_i     (out_ch.out_a),
    .out_b_i     (out_ch.out_b),
    .out_c_i     (out_ch.out_c),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Give up at the cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb failed");
      $finish;
    end
  end

  // Stall the output on a pattern of its own, with one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      out_ch.ready <= 1'b0;
      hold_cnt     <= hold_cnt + 1;
      if (hold_cnt >= 400) hold_done <= 1'b1;
    end else if ((cycles / 128) % 3 == 0) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(3) != 0);
    end
  end

  // Offer one item and hold it until accepted, then maybe open a gap
  task automatic send_point(logic op, logic signed [31:0] a, logic signed [31:0] b,
                            logic signed [31:0] c, int gap);
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.in_a  <= a;
    in_ch.in_b  <= b;
    in_ch.in_c  <= c;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (op == OP_TO_SPH) n_sph++;
    else n_cart++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic signed [31:0] pick_value();
    unique case ($urandom_range(5))
      0:       return $urandom;
      1:       return $signed($urandom_range(32'h7FFF)) - 32'sh4000;
      2:       return $signed($urandom_range(32'h7FFFFF)) - 32'sh400000;
      3:       return $signed($urandom_range(32'h7FFFFFFF)) >>> $urandom_range(12);
      4:       return -($signed($urandom_range(32'h7FFFFFFF)) >>> $urandom_range(12));
      default: return $signed($urandom_range(32'h3FFFFFFF)) - 32'sh20000000;
    endcase
  endfunction

  initial begin
    int burst, gap;
    bit drained;
    logic signed [31:0] hp;
    hp = 32'sd421657428;  // pi/2 in Q4.28
    drained = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op    = OP_TO_SPH;
    in_ch.in_a  = '0;
    in_ch.in_b  = '0;
    in_ch.in_c  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero point, extremes, axes, left half plane, wide angles, negative range
    send_point(OP_TO_SPH, 0, 0, 0, 0);
    send_point(OP_TO_SPH, 0, 0, 32'sh10000, 0);
    send_point(OP_TO_SPH, 0, 0, -32'sh10000, 1);
    send_point(OP_TO_SPH, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0);
    send_point(OP_TO_SPH, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
    send_point(OP_TO_SPH, 32'sh80000000, 32'sh7FFFFFFF, 0, 0);
    send_point(OP_TO_SPH, -32'sh10000, 0, 0, 2);
    send_point(OP_TO_SPH, -32'sh10000, -32'sh1, 32'sh5000, 0);
    send_point(OP_TO_SPH, 0, 32'sh10000, 0, 0);
    send_point(OP_TO_SPH, 32'sh1, -32'sh1, 32'sh1, 0);
    send_point(OP_TO_CART, 0, 0, 0, 0);
    send_point(OP_TO_CART, 32'sh10000, 0, 0, 0);
    send_point(OP_TO_CART, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0);
    send_point(OP_TO_CART, 32'sh80000000, 32'sh80000000, 32'sh80000000, 3);
    send_point(OP_TO_CART, 32'sh10000, hp, -hp, 0);
    send_point(OP_TO_CART, 32'sh10000, hp + 1, hp + 1, 0);
    send_point(OP_TO_CART, 32'sh10000, -hp - 1, 32'sh30000000, 0);
    send_point(OP_TO_CART, -32'sh10000, 32'sh20000000, -32'sh20000000, 0);
    send_point(OP_TO_CART, -32'sh40000000, 32'sh7FFFFFFF, 32'sh80000000, 0);

    // Let the output back up while items keep coming
    hold_req <= 1'b1;
    for (int i = 0; i < 500; i++) begin
      if (!drained && i >= 250) begin
        drained = 1'b1;
        in_ch.valid <= 1'b0;
        wait (pending == 0);
        @(posedge clk_i);
      end
      burst = $urandom_range(1, 20);
      for (int j = 0; j < burst; j++) begin
        gap = (j == burst - 1) ? $urandom_range(0, 8) : 0;
        send_point(1'($urandom_range(1)), pick_value(), pick_value(), pick_value(), gap);
      end
      i += burst - 1;
    end
    for (int i = 0; i < 500; i++) begin
      burst = $urandom_range(1, 20);
      for (int j = 0; j < burst; j++) begin
        gap = (j == burst - 1) ? $urandom_range(0, 8) : 0;
        send_point(1'($urandom_range(1)), pick_value(), pick_value(), pick_value(), gap);
      end
      i += burst - 1;
    end
    in_ch.valid <= 1'b0;

    wait (pending == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("covered %0d Cartesian-to-spherical and %0d spherical-to-Cartesian points,",
             n_sph, n_cart);
    $display("%0d results compared under bursts, output stalls and one long hold-off",
             checked);
    if (errors == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/cs_pkg.sv
rtl/core/cs_in_if.sv
rtl/core/cs_out_if.sv
rtl/core/cs_cordic_stage.sv
rtl/core/cs_cordic.sv
rtl/core/cs_scale.sv
rtl/core/cartesian_spherical_converter.sv
tb/cs_conv_checker.sv
tb/tb.sv
